/* design/layer_norm_vector_macros.svh */
// Assertion macros shared by the layer_norm_vector RTL.
// Expects aclk and aresetn in the scope of each use.
`ifndef LAYER_NORM_VECTOR_MACROS_SVH
`define LAYER_NORM_VECTOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LNV_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("layer_norm_vector: check failed");

// Next-cycle implication, disabled during reset.
`define LNV_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("layer_norm_vector: check failed");

`endif

/* design/lnv_pkg.sv */
// Package for layer_norm_vector: widths and defaults.
// No dependencies.
`timescale 1ns / 1ps
package lnv_pkg;
    localparam int VEC_LEN_DEF = 64;
    localparam int DATA_W      = 16;  // Q8.8 fields
    localparam int EPS_W       = 16;
    localparam int IDX_W       = 6;   // elem_index port
    localparam int N_W         = 7;   // element count, up to 64
    localparam int SUM_W       = 22;  // sum of 64 samples
    localparam int D_W         = 24;  // n*x - sum, signed
    localparam int M_W         = 23;  // |d|
    localparam int SQ_W        = 2 * M_W;
    localparam int S_W         = 52;  // sum of squares
    localparam int T_W         = 53;
    localparam int U_W         = 64;
    localparam int Q_W         = 31;  // root of normalized U
    localparam int E_W         = 5;   // shift pairs, at most 30
    localparam int MN_W        = 30;  // |d|*n
    localparam int QUO_W       = 24;  // quotient bits
    localparam int Z_W         = QUO_W + 1;
    localparam int PROD_W      = Z_W + DATA_W;
    localparam int ACC_W       = 48;
endpackage

/* design/lnv_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module lnv_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* design/lnv_sqrt.sv */
// Bit-pair integer square root, one step per cycle, 31 steps.
// Radicand must lie in [2^60, 2^62). Depends on lnv_pkg.
`timescale 1ns / 1ps
module lnv_sqrt
    import lnv_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [U_W-1:0] radicand,
    output logic           done,
    output logic [Q_W-1:0] root
);
    logic [U_W-1:0] v_reg, res_reg, bit_reg;
    logic           busy_reg, done_reg;
    logic [U_W-1:0] trial;

    assign trial = res_reg + bit_reg;
    assign done  = done_reg;
    assign root  = res_reg[Q_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                v_reg    <= radicand;
                res_reg  <= '0;
                bit_reg  <= U_W'(1) << 60;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (v_reg >= trial) begin
                    v_reg   <= v_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg[0]) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

/* design/lnv_div.sv */
// Restoring divider, one quotient bit per cycle, QUO_W-bit quotient.
// Requires dividend < divisor * 2^QUO_W. Depends on lnv_pkg.
`timescale 1ns / 1ps
module lnv_div
    import lnv_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [U_W-1:0]   dividend,
    input  logic [Q_W-1:0]   divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);
    logic [Q_W-1:0]   rem_reg;
    logic [QUO_W-1:0] low_reg, quo_reg;
    logic [4:0]       step_reg;
    logic             busy_reg, done_reg;
    logic [Q_W:0]     trial;

    assign trial    = {rem_reg, low_reg[QUO_W-1]};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= dividend[QUO_W+Q_W-1:QUO_W];
                low_reg  <= dividend[QUO_W-1:0];
                quo_reg  <= '0;
                step_reg <= 5'(QUO_W - 1);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (trial >= {1'b0, divisor}) begin
                    rem_reg <= Q_W'(trial - {1'b0, divisor});
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
                end else begin
                    rem_reg <= trial[Q_W-1:0];
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
                end
                low_reg <= low_reg << 1;
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg - 5'd1;
                end
            end
        end
    end
endmodule

/* design/layer_norm_vector.sv */
// Top level of layer_norm_vector: buffer, statistics sequencer, output pass.
// Depends on lnv_pkg, lnv_ram, lnv_sqrt, lnv_div, layer_norm_vector_macros.svh.
`timescale 1ns / 1ps
// Layer normalization of one vector of signed Q8.8 elements. Items are taken
// one per cycle into a buffer RAM (sample, gain, offset) until an item with
// s_last_in set; items past VEC_LEN are dropped but a last flag on them still
// closes the vector. The block then runs a mean pass, a squared deviation
// pass, five scaling steps (ST_N2 to ST_U), up to 30 normalizing shift
// pairs, and a 31-step square root. Each element is then read, its deviation
// scaled, divided by the bit-serial divider (skipped for zero spread), scaled
// by gain with offset added, rounded and clipped, and held until the result
// is taken. s_ready is low from the last item until the final result is
// taken. epsilon may be written at any idle time; cfg_ready is always high.
module layer_norm_vector
    import lnv_pkg::*;
#(
    parameter int VEC_LEN = VEC_LEN_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [EPS_W-1:0]         cfg_epsilon,
    // input items
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_sample,
    input  logic signed [DATA_W-1:0] s_gain,
    input  logic signed [DATA_W-1:0] s_offset,
    input  logic                     s_last_in,
    // result items
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_norm_value,
    output logic [IDX_W-1:0]         m_elem_index,
    output logic                     m_clipped,
    output logic                     m_last_out
);
    `include "layer_norm_vector_macros.svh"

    localparam int ADDR_W  = $clog2(VEC_LEN);
    localparam int CNT_W   = $clog2(VEC_LEN + 1);
    localparam int ENTRY_W = 3 * DATA_W;

    typedef enum logic [4:0] {
        ST_LOAD, ST_SUM, ST_SQ, ST_N2, ST_N3, ST_EPS, ST_T, ST_U, ST_NORM,
        ST_ROOT, ST_RD, ST_DEV, ST_MN, ST_NUM, ST_DIVGO, ST_DIV, ST_MUL,
        ST_ACC, ST_OUT
    } state_t;

    state_t                     state_reg;
    logic [EPS_W-1:0]           eps_reg;
    logic [CNT_W-1:0]           cnt_reg, n_reg, rd_ptr_reg;
    logic                       p1_reg, p2_reg, p3_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [D_W-1:0]      d_reg;
    logic [SQ_W-1:0]            sq_reg;
    logic [S_W-1:0]             s_reg;
    logic [13:0]                n2_reg;
    logic [20:0]                n3_reg;
    logic [36:0]                en3_reg;
    logic [T_W-1:0]             t_reg;
    logic [U_W-1:0]             u_reg;
    logic [E_W-1:0]             e_reg;
    logic [Q_W-1:0]             q_reg;
    logic                       q_zero_reg;
    logic signed [DATA_W-1:0]   gain_reg, offset_reg;
    logic [MN_W-1:0]            mn_reg;
    logic [U_W-1:0]             num_reg;
    logic [QUO_W-1:0]           zm_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       m_valid_reg, m_clipped_reg, m_last_reg;
    logic signed [DATA_W-1:0]   m_value_reg;
    logic [IDX_W-1:0]           m_index_reg;

    // buffer RAM
    logic                       ram_we;
    logic [ENTRY_W-1:0]         ram_rdata;
    logic signed [DATA_W-1:0]   rd_sample, rd_gain, rd_offset;
    logic                       s_fire, room;

    // arithmetic
    logic [N_W-1:0]             n_ext;
    logic signed [D_W-1:0]      nx, d_next;
    logic [D_W-1:0]             d_mag;
    logic [5:0]                 shamt;
    logic signed [Z_W-1:0]      z_val;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-17:0]   r_val;

    // root and divider
    logic                       sqrt_start, sqrt_done, div_start, div_done;
    logic [Q_W-1:0]             sqrt_root;
    logic [QUO_W-1:0]           div_quo;

    assign s_ready   = (state_reg == ST_LOAD);
    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;
    assign room      = (cnt_reg < CNT_W'(VEC_LEN));
    assign ram_we    = s_fire && room;

    lnv_ram #(.WIDTH(ENTRY_W), .DEPTH(VEC_LEN)) u_buf (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata ({s_offset, s_gain, s_sample}),
        .raddr (rd_ptr_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_sample = ram_rdata[DATA_W-1:0];
    assign rd_gain   = ram_rdata[2*DATA_W-1:DATA_W];
    assign rd_offset = ram_rdata[3*DATA_W-1:2*DATA_W];

    // deviation scaled by N: d = N*x - sum
    assign n_ext  = N_W'(n_reg);
    assign nx     = D_W'($signed({1'b0, n_ext}) * rd_sample);
    assign d_next = nx - D_W'(sum_reg);
    assign d_mag  = d_reg[D_W-1] ? D_W'(-d_reg) : D_W'(d_reg);
    assign shamt  = 6'(e_reg) + 6'd16;

    assign sqrt_start = (state_reg == ST_NORM) && (u_reg[U_W-1:60] != '0);
    assign div_start  = (state_reg == ST_DIVGO);

    lnv_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (u_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    lnv_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (q_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // output rounding: floor((z*gain + offset*2^16 + 2^15) / 2^16)
    assign z_val = d_reg[D_W-1] ? -$signed({1'b0, zm_reg}) : $signed({1'b0, zm_reg});
    assign acc   = ACC_W'(prod_reg) + (ACC_W'(offset_reg) <<< 16) + ACC_W'(32768);
    assign r_val = acc[ACC_W-1:16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            eps_reg     <= EPS_W'(1);
            cnt_reg     <= '0;
            rd_ptr_reg  <= '0;
            p1_reg      <= 1'b0;
            p2_reg      <= 1'b0;
            p3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                eps_reg <= cfg_epsilon;
            end
            unique case (state_reg)
                ST_LOAD: begin
                    if (s_fire) begin
                        if (room) begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end
                        if (s_last_in) begin
                            n_reg      <= room ? cnt_reg + CNT_W'(1) : cnt_reg;
                            cnt_reg    <= '0;
                            rd_ptr_reg <= '0;
                            sum_reg    <= '0;
                            p1_reg     <= 1'b0;
                            state_reg  <= ST_SUM;
                        end
                    end
                end
                ST_SUM: begin
                    // read one element a cycle, accumulate the one read before
                    p1_reg <= (rd_ptr_reg < n_reg);
                    if (rd_ptr_reg < n_reg) begin
                        rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
                    end
                    if (p1_reg) begin
                        sum_reg <= sum_reg + SUM_W'(rd_sample);
                    end
                    if (rd_ptr_reg == n_reg && !p1_reg && rd_ptr_reg != '0) begin
                        rd_ptr_reg <= '0;
                        s_reg      <= '0;
                        p2_reg     <= 1'b0;
                        p3_reg     <= 1'b0;
                        state_reg  <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    // read -> deviation -> square -> accumulate
                    p1_reg <= (rd_ptr_reg < n_reg);
                    p2_reg <= p1_reg;
                    p3_reg <= p2_reg;
                    if (rd_ptr_reg < n_reg) begin
                        rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
                    end
                    if (p1_reg) begin
                        d_reg <= d_next;
                    end
                    if (p2_reg) begin
                        sq_reg <= d_mag[M_W-1:0] * d_mag[M_W-1:0];
                    end
                    if (p3_reg) begin
                        s_reg <= s_reg + S_W'(sq_reg);
                    end
                    if (rd_ptr_reg == n_reg && !p1_reg && !p2_reg && !p3_reg
                        && rd_ptr_reg != '0) begin
                        state_reg <= ST_N2;
                    end
                end
                ST_N2: begin
                    n2_reg    <= 14'(n_ext * n_ext);
                    state_reg <= ST_N3;
                end
                ST_N3: begin
                    n3_reg    <= 21'(n2_reg * n_ext);
                    state_reg <= ST_EPS;
                end
                ST_EPS: begin
                    en3_reg   <= 37'(eps_reg * n3_reg);
                    state_reg <= ST_T;
                end
                ST_T: begin
                    t_reg     <= T_W'(s_reg) + T_W'(en3_reg);
                    state_reg <= ST_U;
                end
                ST_U: begin
                    u_reg     <= U_W'(t_reg * n_ext);
                    e_reg     <= '0;
                    state_reg <= ST_NORM;
                end
                ST_NORM: begin
                    if (u_reg == '0) begin
                        // zero spread: every result is its offset
                        q_zero_reg <= 1'b1;
                        q_reg      <= '0;
                        rd_ptr_reg <= '0;
                        state_reg  <= ST_RD;
                    end else if (u_reg[U_W-1:60] == '0) begin
                        u_reg <= u_reg << 2;
                        e_reg <= e_reg + E_W'(1);
                    end else begin
                        state_reg <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (sqrt_done) begin
                        q_reg      <= sqrt_root;
                        q_zero_reg <= 1'b0;
                        rd_ptr_reg <= '0;
                        state_reg  <= ST_RD;
                    end
                end
                ST_RD: begin
                    state_reg <= ST_DEV;
                end
                ST_DEV: begin
                    d_reg      <= d_next;
                    gain_reg   <= rd_gain;
                    offset_reg <= rd_offset;
                    state_reg  <= ST_MN;
                end
                ST_MN: begin
                    mn_reg    <= MN_W'(d_mag[M_W-1:0] * n_ext);
                    state_reg <= ST_NUM;
                end
                ST_NUM: begin
                    num_reg <= (U_W'(mn_reg) << shamt) + U_W'(q_reg >> 1);
                    if (q_zero_reg) begin
                        zm_reg    <= '0;
                        state_reg <= ST_MUL;
                    end else begin
                        state_reg <= ST_DIVGO;
                    end
                end
                ST_DIVGO: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        zm_reg    <= div_quo;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= z_val * gain_reg;
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    if (r_val > ACC_W'(32767)) begin
                        m_value_reg   <= 16'sh7FFF;
                        m_clipped_reg <= 1'b1;
                    end else if (r_val < -ACC_W'(32768)) begin
                        m_value_reg   <= -16'sh8000;
                        m_clipped_reg <= 1'b1;
                    end else begin
                        m_value_reg   <= DATA_W'(r_val);
                        m_clipped_reg <= 1'b0;
                    end
                    m_index_reg <= IDX_W'(rd_ptr_reg);
                    m_last_reg  <= (rd_ptr_reg + CNT_W'(1) == n_reg);
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (m_last_reg) begin
                            rd_ptr_reg <= '0;
                            state_reg  <= ST_LOAD;
                        end else begin
                            rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
                            state_reg  <= ST_RD;
                        end
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_norm_value = m_value_reg;
    assign m_elem_index = m_index_reg;
    assign m_clipped    = m_clipped_reg;
    assign m_last_out   = m_last_reg;

    // results never overlap with loading
    `LNV_ASSERT_IMP(a_no_load_while_out, m_valid, !s_ready)
    // buffer fill never passes the vector length
    `LNV_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(VEC_LEN))
    // every result index lies inside the closed vector
    `LNV_ASSERT_IMP(a_index_bound, m_valid, CNT_W'(m_elem_index) < n_reg)
    // taking the final result reopens the input
    `LNV_ASSERT_NXT(a_reopen, m_valid && m_ready && m_last_out, s_ready)
endmodule
